>>> rtl/core/cartridge_bank_controller_mbc1_macros.svh
// Assertion macros for the MBC1 cartridge bank controller.
// Taken in by `include from the files that carry checks; no other dependencies.
`ifndef CARTRIDGE_BANK_CONTROLLER_MBC1_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MBC1_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge outside reset
`define CBM1_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbm1: same-cycle check failed");
// Next-cycle implication
`define CBM1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbm1: next-cycle check failed");
`else
`define CBM1_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CBM1_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/cbm1_pkg.sv
// Package for the MBC1 cartridge bank controller: widths, codes and shared types.
// No dependencies; imported by the interfaces and every module of the block.
package cbm1_pkg;

    // Field widths
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int ROM_ADDR_W = 22;
    localparam int ROM_BANK_W = 8;
    localparam int RAM_BANK_W = 2;
    localparam int ROM_SIZE_W = 5;
    localparam int RAM_CNT_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Cartridge RAM geometry
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_BANKS_MAX  = 4;
    localparam int RAM_DEPTH      = RAM_BANK_BYTES * RAM_BANKS_MAX;
    localparam int RAM_OFF_W      = $clog2(RAM_BANK_BYTES);
    localparam int RAM_IDX_W      = $clog2(RAM_DEPTH);
    localparam int ROM_OFF_W      = 14;

    // ROM size limits (log2 of bytes)
    localparam logic [ROM_SIZE_W-1:0] ROM_LOG2_MIN = ROM_SIZE_W'(15);
    localparam logic [ROM_SIZE_W-1:0] ROM_LOG2_MAX = ROM_SIZE_W'(ROM_ADDR_W);

    // Decode constants
    localparam logic [2:0]            RAM_WINDOW   = 3'b101;
    localparam logic [3:0]            RAM_EN_KEY   = 4'hA;
    localparam logic [DATA_W-1:0]     OPEN_BUS     = 8'hFF;
    localparam logic [ROM_BANK_W-1:0] ROM_HI_MASK  = 8'hE0;

    typedef enum logic [0:0] {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ROM   = 3'd0,
        ST_RAM   = 3'd1,
        ST_OFF   = 3'd2,
        ST_WRITE = 3'd3,
        ST_ERR   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROM_SIZE_LOG2  = 1'b0,
        CFG_RAM_BANK_COUNT = 1'b1
    } cfg_idx_t;

    // Register window selected by address bits 14:13 of a low-half write
    typedef enum logic [1:0] {
        WIN_RAM_EN   = 2'd0,
        WIN_ROM_BANK = 2'd1,
        WIN_HI_BANK  = 2'd2,
        WIN_MODE     = 2'd3
    } reg_win_t;

    typedef struct packed {
        logic                  ram_enable;
        logic                  advanced_mode;
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  dirty;
    } bank_state_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [RAM_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    wdata;
    } ram_access_t;

    localparam bank_state_t BANK_STATE_RESET = '{
        ram_enable:    1'b0,
        advanced_mode: 1'b0,
        rom_bank:      ROM_BANK_W'(1),
        ram_bank:      '0,
        dirty:         1'b0
    };

endpackage

>>> rtl/core/cbm1_if.sv
// Channel interfaces of the MBC1 cartridge bank controller: bus access,
// result and configuration write. Depends on cbm1_pkg.
interface cbm1_req_if
    import cbm1_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output op, output address, output write_data, input ready);
    modport sink   (input valid, input op, input address, input write_data, output ready);
endinterface

interface cbm1_rsp_if
    import cbm1_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [DATA_W-1:0]     read_data;
    logic                  ram_dirty;

    modport source (output valid, output status, output rom_address, output read_data,
                    output ram_dirty, input ready);
    modport sink   (input valid, input status, input rom_address, input read_data,
                    input ram_dirty, output ready);
endinterface

interface cbm1_cfg_if
    import cbm1_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/cbm1_decode.sv
// Access decoder for the MBC1 controller: register writes, ROM mapping and
// cartridge RAM index for one bus access. Pure logic; depends on cbm1_pkg.
module cbm1_decode
    import cbm1_pkg::*;
(
    input  bank_state_t           state,
    input  logic [ROM_SIZE_W-1:0] rom_size_log2,
    input  logic [RAM_CNT_W-1:0]  ram_bank_count,
    input  logic                  op,
    input  logic [ADDR_W-1:0]     address,
    input  logic [DATA_W-1:0]     write_data,
    output bank_state_t           state_next,
    output status_t               status,
    output logic [ROM_ADDR_W-1:0] rom_address,
    output ram_access_t           ram_acc
);

    logic [ROM_SIZE_W-1:0] rom_bits;
    logic [ROM_ADDR_W-1:0] rom_mask;
    logic [ROM_BANK_W-1:0] rom_hi;
    logic [RAM_BANK_W-1:0] bank_mask;
    logic                  ram_present;
    logic                  ram_ok;
    logic                  ram_window;
    logic [RAM_BANK_W-1:0] ram_sel;
    logic [4:0]            low_field;

    // ROM size clamp and address mask
    always_comb
    begin
        if (rom_size_log2 < ROM_LOG2_MIN)
            rom_bits = ROM_LOG2_MIN;
        else if (rom_size_log2 > ROM_LOG2_MAX)
            rom_bits = ROM_LOG2_MAX;
        else
            rom_bits = rom_size_log2;
        for (int i = 0; i < ROM_ADDR_W; i++)
            rom_mask[i] = (ROM_SIZE_W'(i) < rom_bits);
    end

    // Present bank count, limited and rounded down to a power of two
    always_comb
    begin
        ram_present = (ram_bank_count != '0);
        if (ram_bank_count >= RAM_CNT_W'(RAM_BANKS_MAX))
            bank_mask = RAM_BANK_W'(RAM_BANKS_MAX - 1);
        else if (ram_bank_count >= RAM_CNT_W'(2))
            bank_mask = RAM_BANK_W'(1);
        else
            bank_mask = '0;
    end

    assign ram_window = (address[ADDR_W-1 -: 3] == RAM_WINDOW);
    assign ram_ok     = state.ram_enable && ram_present;
    assign ram_sel    = state.advanced_mode ? (state.ram_bank & bank_mask) : '0;
    assign rom_hi     = address[ROM_OFF_W] ? state.rom_bank
                      : (state.advanced_mode ? (state.rom_bank & ROM_HI_MASK) : '0);
    assign low_field  = (write_data[4:0] == '0) ? 5'd1 : write_data[4:0];

    // Access decode and next bank state
    always_comb
    begin
        state_next    = state;
        status        = ST_ERR;
        rom_address   = '0;
        ram_acc.wr_en = 1'b0;
        ram_acc.rd_en = 1'b0;
        ram_acc.idx   = {ram_sel, address[RAM_OFF_W-1:0]};
        ram_acc.wdata = write_data;

        if (op == OP_WRITE)
        begin
            if (!address[ADDR_W-1])
            begin
                status = ST_WRITE;
                unique case (reg_win_t'(address[ADDR_W-2 -: 2]))
                    WIN_RAM_EN:   state_next.ram_enable = (write_data[3:0] == RAM_EN_KEY);
                    WIN_ROM_BANK: state_next.rom_bank   = {state.rom_bank[7:5], low_field};
                    WIN_HI_BANK:
                    begin
                        state_next.ram_bank = write_data[1:0];
                        state_next.rom_bank = {1'b0, write_data[1:0], state.rom_bank[4:0]};
                    end
                    WIN_MODE:     state_next.advanced_mode = write_data[0];
                endcase
            end
            else if (ram_window)
            begin
                status = ST_WRITE;
                if (ram_ok)
                begin
                    ram_acc.wr_en    = 1'b1;
                    state_next.dirty = 1'b1;
                end
            end
        end
        else
        begin
            if (!address[ADDR_W-1])
            begin
                status      = ST_ROM;
                rom_address = {rom_hi, address[ROM_OFF_W-1:0]} & rom_mask;
            end
            else if (ram_window)
            begin
                if (ram_ok)
                begin
                    status        = ST_RAM;
                    ram_acc.rd_en = 1'b1;
                end
                else
                    status = ST_OFF;
            end
        end
    end

endmodule

>>> rtl/core/cartridge_bank_controller_mbc1.sv
// Top level of the MBC1 cartridge bank controller: pipeline registers,
// bank state, cartridge RAM. Depends on cbm1_pkg, cbm1_if, cbm1_decode and the macros header.
//
// Usage:
//   req  - one bus access per transfer (op, address, write_data).
//   rsp  - one result per access (status, rom_address, read_data, ram_dirty),
//          in access order.
//   cfg  - register writes (index 0 rom_size_log2, 1 ram_bank_count); always ready.
//          Write only while no access is in flight.
// Throughput: one access per cycle while rsp is not held. An access transferred
// into req sits in the input register, is decoded against the bank state and the
// RAM, and its result is loaded into the output register, from which rsp is driven.
// Reset: bank state and configuration return to their defaults, then the
// 32768-byte cartridge RAM is cleared one byte a cycle; req.ready stays low for
// the whole clearing pass while cfg writes are still taken.
// Stall: while rsp is held, the output register keeps its result; the input
// register still takes one more access, then req.ready drops until rsp moves.
`include "cartridge_bank_controller_mbc1_macros.svh"

module cartridge_bank_controller_mbc1
    import cbm1_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cbm1_req_if.sink      req,
    cbm1_rsp_if.source    rsp,
    cbm1_cfg_if.sink      cfg
);

    // Configuration
    logic [ROM_SIZE_W-1:0] rom_size_reg;
    logic [RAM_CNT_W-1:0]  ram_count_reg;

    // Bank state
    bank_state_t state_reg;
    bank_state_t state_next;

    // Clearing pass
    logic                 clr_active_reg;
    logic [RAM_IDX_W-1:0] clr_cnt_reg;

    // Input register
    logic              a_valid_reg;
    logic              a_op_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [DATA_W-1:0] a_wdata_reg;

    // Result register
    logic                  b_valid_reg;
    status_t               b_status_reg;
    logic [ROM_ADDR_W-1:0] b_rom_addr_reg;
    logic                  b_dirty_reg;
    logic [DATA_W-1:0]     ram_rdata_reg;

    // Decode results
    status_t               dec_status;
    logic [ROM_ADDR_W-1:0] dec_rom_addr;
    ram_access_t           ram_acc;

    // Cartridge RAM
    logic [DATA_W-1:0]    ram_mem [RAM_DEPTH];
    logic                 mem_we;
    logic [RAM_IDX_W-1:0] mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;

    logic req_xfer;
    logic advance;
    logic move;

    // Handshake
    assign advance   = !b_valid_reg || rsp.ready;
    assign move      = a_valid_reg && advance;
    assign req.ready = !clr_active_reg && (!a_valid_reg || move);
    assign req_xfer  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    cbm1_decode u_decode (
        .state          (state_reg),
        .rom_size_log2  (rom_size_reg),
        .ram_bank_count (ram_count_reg),
        .op             (a_op_reg),
        .address        (a_addr_reg),
        .write_data     (a_wdata_reg),
        .state_next     (state_next),
        .status         (dec_status),
        .rom_address    (dec_rom_addr),
        .ram_acc        (ram_acc)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_reg  <= ROM_LOG2_MIN;
            ram_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_ROM_SIZE_LOG2:  rom_size_reg  <= cfg.data[ROM_SIZE_W-1:0];
                CFG_RAM_BANK_COUNT: ram_count_reg <= cfg.data[RAM_CNT_W-1:0];
            endcase
        end
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == RAM_IDX_W'(RAM_DEPTH - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // Control: valid flags and bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            state_reg   <= BANK_STATE_RESET;
        end
        else
        begin
            if (req_xfer)
                a_valid_reg <= 1'b1;
            else if (move)
                a_valid_reg <= 1'b0;

            if (move)
                b_valid_reg <= 1'b1;
            else if (rsp.ready)
                b_valid_reg <= 1'b0;

            if (move)
                state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            a_op_reg    <= req.op;
            a_addr_reg  <= req.address;
            a_wdata_reg <= req.write_data;
        end
        if (move)
        begin
            b_status_reg   <= dec_status;
            b_rom_addr_reg <= dec_rom_addr;
            b_dirty_reg    <= state_next.dirty;
        end
    end

    // RAM write port: clearing pass or access
    always_comb
    begin
        mem_we    = clr_active_reg || (move && ram_acc.wr_en);
        mem_waddr = clr_active_reg ? clr_cnt_reg : ram_acc.idx;
        mem_wdata = clr_active_reg ? '0 : ram_acc.wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ram_mem[mem_waddr] <= mem_wdata;
        if (move && ram_acc.rd_en)
            ram_rdata_reg <= ram_mem[ram_acc.idx];
    end

    // Result channel
    assign rsp.valid       = b_valid_reg;
    assign rsp.status      = b_status_reg;
    assign rsp.rom_address = b_rom_addr_reg;
    assign rsp.ram_dirty   = b_dirty_reg;

    always_comb
    begin
        unique case (b_status_reg)
            ST_RAM:  rsp.read_data = ram_rdata_reg;
            ST_OFF:  rsp.read_data = OPEN_BUS;
            default: rsp.read_data = '0;
        endcase
    end

    // Checks
    `CBM1_ASSERT_NOW(a_no_req_while_clearing, clk, rst_n, clr_active_reg, !req.ready)
    `CBM1_ASSERT_NEXT(a_dirty_sticky, clk, rst_n, state_reg.dirty, state_reg.dirty)
    `CBM1_ASSERT_NOW(a_rom_bank_low_nonzero, clk, rst_n, 1'b1, state_reg.rom_bank[4:0] != 5'd0)
    `CBM1_ASSERT_NOW(a_rom_addr_only_rom, clk, rst_n, b_valid_reg && (b_status_reg != ST_ROM), b_rom_addr_reg == '0)

endmodule
